// ===== sv/hsgd_pkg.sv =====
// ----------------------------------------------------------------------------
// hsgd_pkg
// Shared types, widths and constants of the head swing gesture detector.
// ----------------------------------------------------------------------------
package hsgd_pkg;

  localparam int WIN_LEN   = 8;
  localparam int WIN_IDX_W = $clog2(WIN_LEN);
  localparam int POS_W     = 16;
  localparam int SUM_W     = POS_W + WIN_IDX_W;
  localparam int CNT_W     = 8;
  localparam int BAND_W    = 12;
  localparam int SWING_W   = 13;
  localparam int DIR_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 13;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic signed [DIR_W-1:0] dir_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SWING = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_COUNT = 2'd3;

  localparam cnt_t                RST_COOLDOWN  = 8'd10;
  localparam logic [BAND_W-1:0]   RST_BAND      = 12'd200;
  localparam logic [SWING_W-1:0]  RST_MIN_SWING = 13'd400;
  localparam cnt_t                RST_CAL_COUNT = 8'd200;
  localparam pos_t                RST_WINDOW    = -16'sd10000;
  localparam pos_t                RST_NEUTRAL   = 16'sd10000;

  localparam dir_t DIR_NONE = 2'sb00;
  localparam dir_t DIR_UP   = 2'sb01;
  localparam dir_t DIR_DOWN = 2'sb11;

endpackage

// ===== sv/head_swing_gesture_detector_core.sv =====
// ----------------------------------------------------------------------------
// head_swing_gesture_detector_core
// Learns a neutral head x position, then flags sideways head swings.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one head x-position sample per item (tdata[15:0], signed,
//   0.1 mm). m_axis returns exactly one result item per sample: tdata[1:0]
//   turn direction (held), tdata[17:2] neutral position, tdata[18]
//   calibrating flag, tdata[23:19] zero.
//   The cfg port writes registers 0..3 (cooldown threshold, neutral band,
//   min swing, calibration count); write only while no item is in flight.
//   The result is registered and valid in the cycle after the sample is accepted.
//   Throughput: one item per cycle unless the receiver stalls; all state
//   updates for a sample happen in the accept cycle through one 8-wide add
//   tree and compare row. The result register lets a new sample enter while
//   the last result is being taken. If the receiver stalls with a result
//   pending, s_axis_tready drops until that result is taken; nothing is lost.
//   Reset: registers return to their defaults, the window to -10000,
//   neutral to 10000, cooldown to 10, and the output register empties.
// ----------------------------------------------------------------------------
module head_swing_gesture_detector_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [hsgd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] position_x
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [1:0] turn_direction, [17:2] neutral_position, [18] calibrating
  output logic [hsgd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                             cfg_we_i,
  input  logic [hsgd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [hsgd_pkg::CFG_W-1:0]       cfg_wdata_i
);
  import hsgd_pkg::*;

  cnt_t                cooldown_thr_q;
  logic [BAND_W-1:0]   band_q;
  logic [SWING_W-1:0]  min_swing_q;
  cnt_t                cal_count_q;

  pos_t                win_q [WIN_LEN];
  pos_t                win_d [WIN_LEN];
  pos_t                neutral_q, neutral_d;
  cnt_t                seen_q, seen_d;
  cnt_t                cool_q, cool_d;
  dir_t                dir_q, dir_d;
  logic                calib;

  logic                out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  logic                accept;
  pos_t                x;
  logic signed [SUM_W-1:0]   sum;
  logic signed [POS_W+1:0]   hi_lim, lo_lim, oldest_ext;
  logic signed [POS_W+1:0]   span_up, span_dn, need;
  logic                in_band, rising, falling;
  dir_t                det;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign x             = pos_t'(s_axis_tdata[POS_W-1:0]);

  always_comb begin
    for (int i = 0; i < WIN_LEN; i++) begin
      win_d[i] = win_q[i];
    end
    neutral_d = neutral_q;
    seen_d    = seen_q;
    cool_d    = cool_q;
    dir_d     = dir_q;
    calib     = seen_q < cal_count_q;

    if (calib && seen_q < CNT_W'(WIN_LEN)) begin
      win_d[seen_q[WIN_IDX_W-1:0]] = x;
    end else begin
      for (int i = 0; i < WIN_LEN - 1; i++) begin
        win_d[i] = win_q[i+1];
      end
      win_d[WIN_LEN-1] = x;
    end

    sum = '0;
    for (int i = 0; i < WIN_LEN; i++) begin
      sum = sum + SUM_W'(win_d[i]);
    end

    oldest_ext = (POS_W+2)'(win_d[0]);
    hi_lim     = (POS_W+2)'(neutral_q) + $signed({6'd0, band_q});
    lo_lim     = (POS_W+2)'(neutral_q) - $signed({6'd0, band_q});
    in_band    = !(oldest_ext > hi_lim || oldest_ext < lo_lim);

    rising  = 1'b1;
    falling = 1'b1;
    for (int i = 0; i < WIN_LEN - 1; i++) begin
      if (win_d[i] > win_d[i+1]) rising = 1'b0;
      if (win_d[i] < win_d[i+1]) falling = 1'b0;
    end
    span_up = (POS_W+2)'(win_d[WIN_LEN-1]) - oldest_ext;
    span_dn = oldest_ext - (POS_W+2)'(win_d[WIN_LEN-1]);
    need    = $signed({5'd0, min_swing_q});

    det = DIR_NONE;
    if (in_band) begin
      if (rising) begin
        det = (span_up >= need) ? DIR_UP : DIR_NONE;
      end else if (falling) begin
        det = (span_dn >= need) ? DIR_DOWN : DIR_NONE;
      end
    end

    if (calib) begin
      if (seen_q >= CNT_W'(WIN_LEN)) begin
        neutral_d = pos_t'(sum >>> WIN_IDX_W);
      end
      seen_d = seen_q + 1'b1;
    end else if (cool_q >= cooldown_thr_q) begin
      dir_d = det;
      if (det != DIR_NONE) cool_d = '0;
    end else begin
      cool_d = cool_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cooldown_thr_q <= RST_COOLDOWN;
      band_q         <= RST_BAND;
      min_swing_q    <= RST_MIN_SWING;
      cal_count_q    <= RST_CAL_COUNT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_COOLDOWN:  cooldown_thr_q <= cfg_wdata_i[CNT_W-1:0];
        CFG_BAND:      band_q         <= cfg_wdata_i[BAND_W-1:0];
        CFG_MIN_SWING: min_swing_q    <= cfg_wdata_i[SWING_W-1:0];
        CFG_CAL_COUNT: cal_count_q    <= cfg_wdata_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WIN_LEN; i++) begin
        win_q[i] <= RST_WINDOW;
      end
      neutral_q <= RST_NEUTRAL;
      seen_q    <= '0;
      cool_q    <= RST_COOLDOWN;
      dir_q     <= DIR_NONE;
    end else if (accept) begin
      for (int i = 0; i < WIN_LEN; i++) begin
        win_q[i] <= win_d[i];
      end
      neutral_q <= neutral_d;
      seen_q    <= seen_d;
      cool_q    <= cool_d;
      dir_q     <= dir_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {(OUT_TDATA_W-DIR_W-POS_W-1)'(0), calib, neutral_d, dir_d};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== sv/hsgd_chk.sv =====
// ----------------------------------------------------------------------------
// hsgd_chk
// Port-level checks for the head swing gesture detector, bound to the core.
// ----------------------------------------------------------------------------
module hsgd_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [hsgd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [hsgd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             cfg_we_i,
  input logic [hsgd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input logic [hsgd_pkg::CFG_W-1:0]       cfg_wdata_i
);
  import hsgd_pkg::*;

  logic unused;
  assign unused = ^{s_axis_tdata, cfg_we_i, cfg_idx_i, cfg_wdata_i};

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // a new result only follows an accepted item
  a_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("result without input item");

  // empty output stage always takes input
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");

  // direction is -1, 0 or +1, padding is zero
  a_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'b10 &&
                      m_axis_tdata[OUT_TDATA_W-1:19] == '0)
    else $error("bad direction code or padding");

endmodule

bind head_swing_gesture_detector_core hsgd_chk u_hsgd_chk (.*);

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stream-level testbench of head_swing_gesture_detector_core. A short
// directed run fills the window, calibrates and drives one rising and one
// falling swing. Random phases follow, under several register settings,
// with monotonic runs of samples around the learned neutral, flat runs and
// noise. A local model of the window, neutral, sample count, cooldown and
// held decision predicts every result item that the directed table does
// not give, and all items are checked field by field in order. Both sides
// idle at random; one phase holds the receiver off for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
  import hsgd_pkg::*;

  typedef struct packed {
    dir_t dir;
    pos_t neutral;
    logic calib;
  } swing_res_t;

  typedef struct packed {
    bit         typed;
    swing_res_t res;
    pos_t       pos;
  } stim_row_t;

  localparam bit TYPED = 1'b1;
  localparam bit PRED  = 1'b0;

  localparam swing_res_t FILL_RES = '{DIR_NONE, RST_NEUTRAL, 1'b1};
  localparam swing_res_t UP_RES   = '{DIR_UP, 16'sd0, 1'b0};
  localparam swing_res_t DOWN_RES = '{DIR_DOWN, 16'sd0, 1'b0};
  localparam swing_res_t NO_RES   = '0;

  localparam int IDLE_PCT       = 7;
  localparam int HOLD_CYCLES    = 100;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_PHASES       = 7;
  localparam int PHASE_ITEMS    = 200;
  localparam int TAIL_CYCLES    = 5;

  // fill with extremes, two calibration samples (neutral ends at 0),
  // then a rising and a falling swing
  localparam int N_DIRECTED = 25;
  localparam stim_row_t DIRECTED_STIM [N_DIRECTED] = '{
    '{TYPED, FILL_RES, 16'sh7fff},
    '{TYPED, FILL_RES, 16'sh8000},
    '{TYPED, FILL_RES, 16'sd0},
    '{TYPED, FILL_RES, 16'sd1},
    '{TYPED, FILL_RES, -16'sd1},
    '{TYPED, FILL_RES, 16'sd100},
    '{TYPED, FILL_RES, -16'sd100},
    '{TYPED, FILL_RES, 16'sd0},
    '{PRED,  NO_RES,   16'sd0},
    '{PRED,  NO_RES,   16'sd0},
    '{PRED,  NO_RES,   16'sd0},
    '{PRED,  NO_RES,   16'sd100},
    '{PRED,  NO_RES,   16'sd200},
    '{PRED,  NO_RES,   16'sd300},
    '{PRED,  NO_RES,   16'sd400},
    '{PRED,  NO_RES,   16'sd500},
    '{PRED,  NO_RES,   16'sd600},
    '{TYPED, UP_RES,   16'sd700},
    '{PRED,  NO_RES,   16'sd600},
    '{PRED,  NO_RES,   16'sd500},
    '{PRED,  NO_RES,   16'sd400},
    '{PRED,  NO_RES,   16'sd300},
    '{PRED,  NO_RES,   16'sd200},
    '{PRED,  NO_RES,   16'sd100},
    '{TYPED, DOWN_RES, 16'sd0}
  };

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_W-1:0]       cfg_wdata_i;

  head_swing_gesture_detector_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [15:0] position_x
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    // [1:0] turn_direction, [17:2] neutral_position, [18] calibrating
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // swing tracker state and its copy of the registers
  pos_t               win_q [WIN_LEN];
  pos_t               neutral_q;
  cnt_t               seen_q;
  cnt_t               cool_q;
  dir_t               held_q;
  cnt_t               cfg_cooldown;
  logic [BAND_W-1:0]  cfg_band;
  logic [SWING_W-1:0] cfg_swing;
  cnt_t               cfg_cal;

  swing_res_t pending_res [$];
  int         fail_cnt;
  int         idle_cycles;
  bit         quiet;
  bit         hold_req;

  swing_res_t want_res;
  dir_t       got_dir;
  pos_t       got_neutral;
  logic       got_calib;

  task automatic reset_tracker();
    for (int i = 0; i < WIN_LEN; i++) begin
      win_q[i] = RST_WINDOW;
    end
    neutral_q    = RST_NEUTRAL;
    seen_q       = '0;
    cool_q       = RST_COOLDOWN;
    held_q       = DIR_NONE;
    cfg_cooldown = RST_COOLDOWN;
    cfg_band     = RST_BAND;
    cfg_swing    = RST_MIN_SWING;
    cfg_cal      = RST_CAL_COUNT;
  endtask

  function automatic pos_t clamp_pos(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return pos_t'(v);
  endfunction

  function automatic swing_res_t track_sample(pos_t x);
    swing_res_t r;
    int         sum;
    int         band;
    int         span;
    bit         in_band;
    bit         up;
    bit         dn;
    dir_t       d;
    r.calib = 1'b0;
    if (seen_q < cfg_cal) begin
      r.calib = 1'b1;
      if (seen_q < WIN_LEN) begin
        win_q[seen_q[WIN_IDX_W-1:0]] = x;
      end else begin
        for (int i = 0; i < WIN_LEN - 1; i++) win_q[i] = win_q[i+1];
        win_q[WIN_LEN-1] = x;
        sum = 0;
        for (int i = 0; i < WIN_LEN; i++) sum += int'(win_q[i]);
        neutral_q = pos_t'(sum >>> WIN_IDX_W);
      end
      seen_q++;
    end else begin
      for (int i = 0; i < WIN_LEN - 1; i++) win_q[i] = win_q[i+1];
      win_q[WIN_LEN-1] = x;
      if (cool_q >= cfg_cooldown) begin
        band    = int'(cfg_band);
        in_band = !(int'(win_q[0]) > int'(neutral_q) + band ||
                    int'(win_q[0]) < int'(neutral_q) - band);
        up = 1'b1;
        dn = 1'b1;
        for (int i = 0; i < WIN_LEN - 1; i++) begin
          if (win_q[i] > win_q[i+1]) up = 1'b0;
          if (win_q[i] < win_q[i+1]) dn = 1'b0;
        end
        span = int'(win_q[WIN_LEN-1]) - int'(win_q[0]);
        d = DIR_NONE;
        if (in_band) begin
          if (up) d = (span >= int'(cfg_swing)) ? DIR_UP : DIR_NONE;
          else if (dn) d = (-span >= int'(cfg_swing)) ? DIR_DOWN : DIR_NONE;
        end
        held_q = d;
        if (d != DIR_NONE) cool_q = '0;
      end else begin
        cool_q++;
      end
    end
    r.dir     = held_q;
    r.neutral = neutral_q;
    return r;
  endfunction

  task automatic program_regs(cnt_t cd, logic [BAND_W-1:0] band,
                              logic [SWING_W-1:0] swing, cnt_t cal);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_COOLDOWN;
    cfg_wdata_i <= CFG_W'(cd);
    @(negedge clk_i);
    cfg_idx_i   <= CFG_BAND;
    cfg_wdata_i <= CFG_W'(band);
    @(negedge clk_i);
    cfg_idx_i   <= CFG_MIN_SWING;
    cfg_wdata_i <= CFG_W'(swing);
    @(negedge clk_i);
    cfg_idx_i   <= CFG_CAL_COUNT;
    cfg_wdata_i <= CFG_W'(cal);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_cooldown = cd;
    cfg_band     = band;
    cfg_swing    = swing;
    cfg_cal      = cal;
  endtask

  task automatic send_sample(pos_t pos, bit typed, swing_res_t typed_res);
    swing_res_t r;
    @(negedge clk_i);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pos;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = track_sample(pos);
    pending_res.push_back(typed ? typed_res : r);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // mostly monotonic runs around neutral, with flat runs, breaks and noise
  task automatic run_random(int n_items);
    int sent;
    int len;
    int start;
    int step;
    int sgn;
    int v;
    int k;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 15) begin
        send_sample(pos_t'($urandom), PRED, NO_RES);
        sent++;
      end else begin
        len   = $urandom_range(WIN_LEN, WIN_LEN + 4);
        start = int'(neutral_q) - int'(cfg_band) - 20 +
                int'($urandom_range(0, 2 * int'(cfg_band) + 40));
        case ($urandom_range(9))
          0: step = 0;
          1, 2: step = $urandom_range(0, 600);
          default: step = (int'(cfg_swing) + 6) / 7 + int'($urandom_range(0, 4)) - 2;
        endcase
        if (step < 0) step = 0;
        sgn = $urandom_range(1) ? 1 : -1;
        for (k = 0; k < len; k++) begin
          v = start + sgn * step * k;
          if ($urandom_range(99) < 4) v = start + int'($urandom_range(0, 2000)) - 1000;
          send_sample(clamp_pos(v), PRED, NO_RES);
        end
        sent += len;
      end
    end
  endtask

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        m_axis_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_res.size() == 0) begin
          $error("result item with nothing pending: tdata %h", m_axis_tdata);
          fail_cnt++;
        end else begin
          want_res    = pending_res.pop_front();
          got_dir     = m_axis_tdata[1:0];
          got_neutral = m_axis_tdata[17:2];
          got_calib   = m_axis_tdata[18];
          if (got_dir !== want_res.dir) begin
            $error("turn_direction: expected %0d, actual %0d", want_res.dir, got_dir);
            fail_cnt++;
          end
          if (got_neutral !== want_res.neutral) begin
            $error("neutral_position: expected %0d, actual %0d",
                   want_res.neutral, got_neutral);
            fail_cnt++;
          end
          if (got_calib !== want_res.calib) begin
            $error("calibrating: expected %0d, actual %0d", want_res.calib, got_calib);
            fail_cnt++;
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL head_swing_gesture_detector_core");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_COOLDOWN;
    cfg_wdata_i   = '0;
    fail_cnt      = 0;
    idle_cycles   = 0;
    quiet         = 1'b0;
    hold_req      = 1'b0;
    reset_tracker();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    program_regs(8'd0, 12'd4095, 13'd400, 8'd10);
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_sample(DIRECTED_STIM[i].pos, DIRECTED_STIM[i].typed, DIRECTED_STIM[i].res);
    end
    drain();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: program_regs(8'd0, 12'd4095, 13'd0, 8'd8);
        1: program_regs(8'd255, 12'd0, 13'd8191, 8'd255);
        2: program_regs(8'd3, 12'd200, 13'd400, 8'd255);
        default: begin
          program_regs(cnt_t'($urandom_range(0, 12)),
                       ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 800)),
                       13'($urandom_range(0, 2000)),
                       cnt_t'($urandom_range(8, 255)));
        end
      endcase
      if (ph == 3) hold_req = 1'b1;
      quiet = (ph == 4);
      run_random(PHASE_ITEMS);
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0 && pending_res.size() == 0) begin
      $display("PASS head_swing_gesture_detector_core");
    end else begin
      $display("FAIL head_swing_gesture_detector_core");
    end
    $finish;
  end

endmodule
